### design/lztbe_pkg.sv
// ----------------------------------------------------------------------------
// lztbe_pkg: shared types and constants of the LZ token bit-stream encoder
// Token codes, FSM state types, inter-module control structs.
// ----------------------------------------------------------------------------
package lztbe_pkg;

  // defaults for the top-level parameters
  localparam int DIST_BITS_DEF = 16;
  localparam int LEN_BITS_DEF  = 16;

  localparam logic [15:0] FAR_LIMIT_RESET = 16'd1920;

  localparam int TAG_BITS    = 8;   // bits in one tag word
  localparam int LOW_BITS    = 6;   // raw low distance bits after the gamma code
  localparam int MAX_RESULTS = 18;  // words kept per token, the rest dropped
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // request kinds on in_tuser
  localparam logic [1:0] REQ_LIT   = 2'd0;
  localparam logic [1:0] REQ_MATCH = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_DECIDE,
    SQ_RAW,
    SQ_LIT1,
    SQ_LIT2,
    SQ_MTAG,
    SQ_GNORM,
    SQ_GDATA,
    SQ_GCONT,
    SQ_REP0,
    SQ_REP1,
    SQ_DLOW,
    SQ_FLUSH,
    SQ_FIN
  } seq_state_t;

  typedef enum logic [1:0] {
    PK_IDLE,
    PK_TAG,
    PK_HELD
  } pk_state_t;

  // sequencer -> tag packer command, held until acknowledged
  typedef struct packed {
    logic       bit_req;    // append one tag bit
    logic       bit_val;
    logic       lit_en;     // with the bit, hold data as a literal
    logic       flush_req;  // end of data: send partial tag word and held bytes
    logic       raw_req;    // send data straight out (verbatim first literal)
    logic [7:0] data;
  } pk_cmd_t;

  // packer -> output stage word
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } emit_t;

  // sequencer -> output stage end-of-token marker
  typedef struct packed {
    logic req;
    logic stream_end;
  } fin_t;

endpackage

### design/lztbe_pack.sv
// ----------------------------------------------------------------------------
// lztbe_pack: tag word packer
// Shifts tag bits into the tag word, holds literal bytes, sends the tag word
// ahead of its held bytes when full or at end of data; raw bytes pass through.
// ----------------------------------------------------------------------------
module lztbe_pack
  import lztbe_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  pk_cmd_t cmd,
  output logic    ack,
  output emit_t   emit,
  input  logic    emit_ready
);

  pk_state_t   state_r, state_nxt;
  logic [7:0]  tag_r;
  logic [3:0]  used_r;
  logic [7:0]  held_r [TAG_BITS];
  logic [3:0]  held_cnt_r;
  logic [2:0]  rd_idx_r;

  logic        take_bit, clr, rd_step, held_last;
  logic [3:0]  shamt;
  logic [7:0]  flush_word;

  assign shamt      = 4'(TAG_BITS) - used_r;
  assign flush_word = 8'(tag_r << shamt);
  assign held_last  = (4'(rd_idx_r) + 4'd1) == held_cnt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PK_IDLE: begin
        if ((cmd.bit_req && used_r == 4'(TAG_BITS)) || cmd.flush_req) state_nxt = PK_TAG;
      end
      PK_TAG: begin
        if (emit_ready) state_nxt = (held_cnt_r == 4'd0) ? PK_IDLE : PK_HELD;
      end
      PK_HELD: begin
        if (emit_ready && held_last) state_nxt = PK_IDLE;
      end
      default: state_nxt = PK_IDLE;
    endcase
  end

  always_comb begin
    emit     = '0;
    ack      = 1'b0;
    take_bit = 1'b0;
    clr      = 1'b0;
    rd_step  = 1'b0;
    case (state_r)
      PK_IDLE: begin
        if (cmd.raw_req) begin
          emit.valid = 1'b1;
          emit.data  = cmd.data;
          ack        = emit_ready;
        end else if (cmd.bit_req && used_r != 4'(TAG_BITS)) begin
          take_bit = 1'b1;
          ack      = 1'b1;
        end
      end
      PK_TAG: begin
        emit.valid = 1'b1;
        emit.data  = flush_word;
        if (emit_ready && held_cnt_r == 4'd0) begin
          clr = 1'b1;
          ack = cmd.flush_req;
        end
      end
      PK_HELD: begin
        emit.valid = 1'b1;
        emit.data  = held_r[rd_idx_r];
        if (emit_ready) begin
          rd_step = 1'b1;
          if (held_last) begin
            clr = 1'b1;
            ack = cmd.flush_req;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= PK_IDLE;
      tag_r      <= '0;
      used_r     <= '0;
      held_cnt_r <= '0;
      rd_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        tag_r      <= '0;
        used_r     <= '0;
        held_cnt_r <= '0;
      end else if (take_bit) begin
        tag_r  <= {tag_r[6:0], cmd.bit_val};
        used_r <= used_r + 4'd1;
        if (cmd.lit_en) held_cnt_r <= held_cnt_r + 4'd1;
      end
      if (state_r != PK_HELD) rd_idx_r <= '0;
      else if (rd_step)       rd_idx_r <= rd_idx_r + 3'd1;
    end
  end

  // held literal bytes, no reset
  always_ff @(posedge clk) begin
    if (take_bit && cmd.lit_en) held_r[held_cnt_r[2:0]] <= cmd.data;
  end

endmodule

### design/lztbe_out.sv
// ----------------------------------------------------------------------------
// lztbe_out: result stage
// One-word look-ahead to mark the last word of a token, output register.
// ----------------------------------------------------------------------------
module lztbe_out
  import lztbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  emit_t      emit,
  output logic       emit_ready,
  input  fin_t       fin,
  output logic       fin_ack,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  logic                 hold_v_r;
  logic [7:0]           hold_data_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic                 o_v_r, o_last_r, o_end_r;
  logic [7:0]           o_data_r;

  logic o_free, capped, emit_take, push_emit, push_fin;

  assign o_free     = !o_v_r || out_tready;
  assign capped     = cnt_r >= RES_CNT_W'(MAX_RESULTS);
  assign emit_ready = capped || !hold_v_r || o_free;
  assign emit_take  = emit.valid && emit_ready && !capped;
  assign push_emit  = emit_take && hold_v_r;
  assign fin_ack    = !hold_v_r || o_free;
  assign push_fin   = fin.req && fin_ack && hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      cnt_r    <= '0;
      o_v_r    <= 1'b0;
    end else begin
      if (emit_take) begin
        hold_v_r <= 1'b1;
        cnt_r    <= cnt_r + RES_CNT_W'(1);
      end else if (fin.req && fin_ack) begin
        hold_v_r <= 1'b0;
        cnt_r    <= '0;
      end
      if (push_emit || push_fin) o_v_r <= 1'b1;
      else if (out_tready)       o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) hold_data_r <= emit.data;
    if (push_emit || push_fin) begin
      o_data_r <= hold_data_r;
      o_last_r <= push_fin;
      o_end_r  <= push_fin && fin.stream_end;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_end_r;

endmodule

### design/lztbe_seq.sv
// ----------------------------------------------------------------------------
// lztbe_seq: token sequencer
// Decides the coding of a token and feeds tag bits, one per cycle while the
// packer acknowledges, from the gamma shift register and low distance shifter.
// ----------------------------------------------------------------------------
module lztbe_seq
  import lztbe_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int LEN_BITS  = LEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_first,
  input  logic [7:0]           in_second,
  input  logic [DIST_BITS-1:0] in_dist,
  input  logic [LEN_BITS-1:0]  in_len,
  input  logic [15:0]          far_limit,
  output pk_cmd_t              pk_cmd,
  input  logic                 pk_ack,
  output fin_t                 fin,
  input  logic                 fin_ack
);

  // gamma shifter covers the length and the distance high part plus bias
  localparam int GW = (LEN_BITS > DIST_BITS - LOW_BITS + 1) ? LEN_BITS
                                                            : DIST_BITS - LOW_BITS + 1;
  localparam int RW = $clog2(GW + 1);
  localparam int CW = (DIST_BITS > 16) ? DIST_BITS : 16;

  seq_state_t state_r, state_nxt;

  logic [1:0]           kind_r;
  logic [7:0]           b0_r, b1_r;
  logic [DIST_BITS-1:0] dist_r, d1_r, prev_dist_r;
  logic [LEN_BITS-1:0]  len_r;
  logic                 started_r, prev_match_r, end_r;
  logic                 two_r, rep_r, glen_r;
  logic [GW-1:0]        gsr_r, dv_r;
  logic [RW-1:0]        rem_r;
  logic [LOW_BITS-1:0]  low_r;
  logic [2:0]           lcnt_r;

  logic                 far, len_two, rep, lits, dec, use_rep, bias3, norm_more;
  logic [LEN_BITS-1:0]  len_eff;
  logic [GW-1:0]        dv;

  // coding decision, evaluated in SQ_DECIDE
  always_comb begin
    far     = CW'(dist_r) > CW'(far_limit);
    len_two = len_r == LEN_BITS'(2);
    rep     = (prev_dist_r != '0) && (dist_r == prev_dist_r);
    if (prev_match_r) begin
      lits    = far && len_two;
      dec     = far;
      use_rep = 1'b0;
      bias3   = 1'b0;
    end else begin
      lits    = far && len_two && !rep;
      dec     = far && !rep;
      use_rep = rep;
      bias3   = 1'b1;
    end
    len_eff = dec ? (len_r - LEN_BITS'(1)) : len_r;
    dv      = GW'(d1_r >> LOW_BITS) + (bias3 ? GW'(3) : GW'(2));
  end

  assign norm_more = !gsr_r[GW-1] && (rem_r > RW'(2));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SQ_IDLE: begin
        if (in_valid) state_nxt = SQ_DECIDE;
      end
      SQ_DECIDE: begin
        case (kind_r)
          REQ_LIT:   state_nxt = started_r ? SQ_LIT1 : SQ_RAW;
          REQ_MATCH: state_nxt = lits ? SQ_LIT1 : SQ_MTAG;
          REQ_END:   state_nxt = started_r ? SQ_FLUSH : SQ_FIN;
          default:   state_nxt = SQ_FIN;
        endcase
      end
      SQ_RAW:   if (pk_ack) state_nxt = SQ_FIN;
      SQ_LIT1:  if (pk_ack) state_nxt = two_r ? SQ_LIT2 : SQ_FIN;
      SQ_LIT2:  if (pk_ack) state_nxt = SQ_FIN;
      SQ_MTAG:  if (pk_ack) state_nxt = SQ_GNORM;
      SQ_GNORM: if (!norm_more) state_nxt = SQ_GDATA;
      SQ_GDATA: if (pk_ack) state_nxt = SQ_GCONT;
      SQ_GCONT: begin
        if (pk_ack) begin
          if (rem_r == RW'(1)) begin
            if (glen_r) state_nxt = rep_r ? SQ_REP0 : SQ_GNORM;
            else        state_nxt = SQ_DLOW;
          end else begin
            state_nxt = SQ_GDATA;
          end
        end
      end
      SQ_REP0:  if (pk_ack) state_nxt = SQ_REP1;
      SQ_REP1:  if (pk_ack) state_nxt = SQ_FIN;
      SQ_DLOW:  if (pk_ack && lcnt_r == 3'd0) state_nxt = SQ_FIN;
      SQ_FLUSH: if (pk_ack) state_nxt = SQ_FIN;
      SQ_FIN:   if (fin_ack) state_nxt = SQ_IDLE;
      default:  state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    pk_cmd   = '0;
    fin      = '0;
    in_ready = 1'b0;
    case (state_r)
      SQ_IDLE: in_ready = 1'b1;
      SQ_RAW: begin
        pk_cmd.raw_req = 1'b1;
        pk_cmd.data    = b0_r;
      end
      SQ_LIT1: begin
        pk_cmd.bit_req = 1'b1;
        pk_cmd.lit_en  = 1'b1;
        pk_cmd.data    = b0_r;
      end
      SQ_LIT2: begin
        pk_cmd.bit_req = 1'b1;
        pk_cmd.lit_en  = 1'b1;
        pk_cmd.data    = b1_r;
      end
      SQ_MTAG: begin
        pk_cmd.bit_req = 1'b1;
        pk_cmd.bit_val = 1'b1;
      end
      SQ_GDATA: begin
        pk_cmd.bit_req = 1'b1;
        pk_cmd.bit_val = gsr_r[GW-1];
      end
      SQ_GCONT: begin
        pk_cmd.bit_req = 1'b1;
        pk_cmd.bit_val = rem_r != RW'(1);
      end
      SQ_REP0, SQ_REP1: pk_cmd.bit_req = 1'b1;
      SQ_DLOW: begin
        pk_cmd.bit_req = 1'b1;
        pk_cmd.bit_val = low_r[LOW_BITS-1];
      end
      SQ_FLUSH: pk_cmd.flush_req = 1'b1;
      SQ_FIN: begin
        fin.req        = 1'b1;
        fin.stream_end = end_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SQ_IDLE;
      started_r    <= 1'b0;
      prev_dist_r  <= '0;
      prev_match_r <= 1'b0;
      end_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        SQ_DECIDE: begin
          end_r <= 1'b0;
          if (kind_r == REQ_LIT) begin
            started_r <= 1'b1;
            if (started_r) prev_match_r <= 1'b0;
          end else if (kind_r == REQ_MATCH) begin
            started_r    <= 1'b1;
            prev_match_r <= !lits;
            if (!lits) prev_dist_r <= dist_r;
          end
        end
        SQ_FLUSH: begin
          if (pk_ack) begin
            started_r    <= 1'b0;
            prev_dist_r  <= '0;
            prev_match_r <= 1'b0;
            end_r        <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // token payload and shifters
  always_ff @(posedge clk) begin
    case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          kind_r <= in_kind;
          b0_r   <= in_first;
          b1_r   <= in_second;
          dist_r <= in_dist;
          d1_r   <= in_dist - DIST_BITS'(1);
          len_r  <= (in_len < LEN_BITS'(2)) ? LEN_BITS'(2) : in_len;
        end
      end
      SQ_DECIDE: begin
        two_r  <= (kind_r == REQ_MATCH) && lits;
        rep_r  <= use_rep;
        glen_r <= 1'b1;
        gsr_r  <= GW'(len_eff);
        rem_r  <= RW'(GW);
        dv_r   <= dv;
        low_r  <= d1_r[LOW_BITS-1:0];
        lcnt_r <= 3'(LOW_BITS - 1);
      end
      SQ_GNORM: begin
        // skip leading zeros, the final shift drops the implied top bit
        gsr_r <= gsr_r << 1;
        rem_r <= rem_r - RW'(1);
      end
      SQ_GCONT: begin
        if (pk_ack) begin
          if (rem_r == RW'(1) && glen_r && !rep_r) begin
            gsr_r  <= dv_r;
            rem_r  <= RW'(GW);
            glen_r <= 1'b0;
          end else begin
            gsr_r <= gsr_r << 1;
            rem_r <= rem_r - RW'(1);
          end
        end
      end
      SQ_DLOW: begin
        if (pk_ack) begin
          low_r  <= low_r << 1;
          lcnt_r <= lcnt_r - 3'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/lz_token_bitstream_encoder_core.sv
// ----------------------------------------------------------------------------
// lz_token_bitstream_encoder_core: LZ token to packed byte stream encoder
// Gamma2 tag-bit coding of literals and matches, tag words sent ahead of
// the literal bytes they govern.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  -----------------------------------------
//  in_      in   in_tvalid/in_tready   tdata: first/second byte, distance, length
//                                      tuser: request kind
//  out_     out  out_tvalid/out_tready tdata: stream word; tlast: last word of
//                                      the token; tuser: last word of stream
//  cfg_     in   cfg_we                far_short_limit, 16 bit
//
//  Per token: a literal is accepted, decided, given its tag bit and finished.
//  A match sends its tag bit, 6 low distance bits (2 for a repeat) and per
//  gamma code a normalising shift past leading zeros, then two tag bits per
//  code bit, from a GW-bit shifter, GW = max(LEN_BITS, DIST_BITS-5). One
//  token is in work at a time. A stalled out_tready holds the packer;
//  in_tready stays low until the token's last word has entered the output
//  register. Reset: synchronous, active low, limit back to 1920, no
//  clearing pass.
//
module lz_token_bitstream_encoder_core
  import lztbe_pkg::*;
#(
  parameter int DIST_BITS = DIST_BITS_DEF,
  parameter int LEN_BITS  = LEN_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // [7:0] first_byte, [15:8] second_byte, [16+:DIST_BITS] match_distance,
  // then match_length, zero fill to whole bytes
  input  logic [((16+DIST_BITS+LEN_BITS+7)/8)*8-1:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]                               in_tuser,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // [7:0] out_byte
  output logic [7:0]                               out_tdata,
  // [0] stream_end
  output logic [0:0]                               out_tuser,
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  input  logic                                     cfg_we,
  input  logic [15:0]                              cfg_wdata
);

  localparam int DIST_LSB = 16;
  localparam int LEN_LSB  = DIST_LSB + DIST_BITS;

  logic [15:0] far_limit_r;
  pk_cmd_t     pk_cmd;
  logic        pk_ack;
  emit_t       emit;
  logic        emit_ready;
  fin_t        fin;
  logic        fin_ack;
  logic        end_bit;

  // far_short_limit register, write only
  always_ff @(posedge clk) begin
    if (!rst_n)      far_limit_r <= FAR_LIMIT_RESET;
    else if (cfg_we) far_limit_r <= cfg_wdata;
  end

  lztbe_seq #(
    .DIST_BITS (DIST_BITS),
    .LEN_BITS  (LEN_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_first  (in_tdata[7:0]),
    .in_second (in_tdata[15:8]),
    .in_dist   (in_tdata[DIST_LSB +: DIST_BITS]),
    .in_len    (in_tdata[LEN_LSB +: LEN_BITS]),
    .far_limit (far_limit_r),
    .pk_cmd    (pk_cmd),
    .pk_ack    (pk_ack),
    .fin       (fin),
    .fin_ack   (fin_ack)
  );

  // tag word shifting and literal holding
  lztbe_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (pk_cmd),
    .ack        (pk_ack),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  // look-ahead register marks the token's last word, then output register
  lztbe_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .emit_ready (emit_ready),
    .fin        (fin),
    .fin_ack    (fin_ack),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (end_bit)
  );

  assign out_tuser = end_bit;

endmodule
